### src/dbts_pkg.sv
// ----------------------------------------------------------------------------
// dbts_pkg
// Shared types and constants for the dual band deadline transmit scheduler.
// ----------------------------------------------------------------------------
package dbts_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_PAYLOAD = 1023;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = IDX_W + 1;
  localparam int ENTRY_W = 64 + 32 + 16 + 10;

  localparam logic [7:0] CHAN_LOW = 8'd6;
  localparam logic [7:0] CHAN_HIGH = 8'd149;

  localparam logic [1:0] CMD_SUBMIT = 2'd0;
  localparam logic [1:0] CMD_POLL = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_COUNTRY = 3'd3;
  localparam logic [2:0] ST_CHANNEL = 3'd4;
  localparam logic [2:0] ST_TRANSMIT = 3'd5;

  localparam logic [1:0] CNT_EXPECTED = 2'd0;
  localparam logic [1:0] CNT_SUBMITTED = 2'd1;
  localparam logic [1:0] CNT_LATE = 2'd2;
  localparam logic [1:0] CNT_ERRORS = 2'd3;

  localparam logic CFG_DWELL = 1'b0;
  localparam logic CFG_RETRY = 1'b1;

  typedef struct packed {
    logic [63:0] deadline;
    logic [31:0] sequence_number;
    logic [15:0] handle;
    logic [9:0] length;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_ISSUE,
    S_SHIFT,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic decide;     // submit / read / poll head decisions
    logic scan_start; // begin scan at slot zero
    logic scan_step;  // compare next slot
    logic issue;      // finish the poll with the best entry
    logic shift_step; // move one entry down
    logic done;       // present the result word
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic go_scan;    // poll goes on to selection
    logic scan_last;  // scan has seen every slot
    logic need_shift; // issued entry must be removed
    logic shift_last; // shift has reached the tail
  } stat_t;

endpackage

### src/dbts_ram.sv
// ----------------------------------------------------------------------------
// dbts_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/dbts_ctrl.sv
// ----------------------------------------------------------------------------
// dbts_ctrl
// Sequencer for one command: decide, scan the band queue, issue, shift down.
// ----------------------------------------------------------------------------
module dbts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_take,
  input  logic           out_free,
  input  dbts_pkg::stat_t stat,
  output dbts_pkg::ctrl_t ctrl,
  output logic           busy,
  output logic           result_valid
);
  import dbts_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_take) state_next = S_DECIDE;
      S_DECIDE: state_next = stat.go_scan ? S_SCAN : S_DONE;
      S_SCAN:   if (stat.scan_last) state_next = S_ISSUE;
      S_ISSUE:  state_next = stat.need_shift ? S_SHIFT : S_DONE;
      S_SHIFT:  if (stat.shift_last) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    result_valid = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        ctrl.load = in_take;
      end
      S_DECIDE: begin
        ctrl.decide = 1'b1;
        ctrl.scan_start = stat.go_scan;
      end
      S_SCAN:  ctrl.scan_step = 1'b1;
      S_ISSUE: ctrl.issue = 1'b1;
      S_SHIFT: ctrl.shift_step = 1'b1;
      S_DONE: begin
        result_valid = 1'b1;
        ctrl.done = out_free;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

### src/dbts_dp.sv
// ----------------------------------------------------------------------------
// dbts_dp
// Datapath: entry RAM, queue counts, channel state and band counters.
// ----------------------------------------------------------------------------
module dbts_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  dbts_pkg::ctrl_t       ctrl,
  output dbts_pkg::stat_t       stat,
  input  logic                  cfg_we,
  input  logic                  cfg_idx,
  input  logic [31:0]           cfg_data,
  input  logic [1:0]            command,
  input  logic [1:0]            transport,
  input  logic [63:0]           deadline,
  input  logic [31:0]           sequence_number,
  input  logic [15:0]           payload_handle,
  input  logic [9:0]            payload_length,
  input  logic [63:0]           now,
  input  logic                  country_ok,
  input  logic                  channel_ok,
  input  logic                  transmit_ok,
  input  logic [1:0]            counter_select,
  output logic [2:0]            status,
  output logic                  country_request,
  output logic [7:0]            channel_request,
  output logic                  tx_valid,
  output logic [15:0]           tx_handle,
  output logic [9:0]            tx_length,
  output logic                  tx_late,
  output logic [63:0]           read_value,
  output logic [3:0]            low_band_depth,
  output logic [3:0]            high_band_depth
);
  import dbts_pkg::*;

  // configuration
  logic [31:0] dwell_time, retry_delay;
  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_time <= 32'd100;
      retry_delay <= 32'd50;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_DWELL) dwell_time <= cfg_data;
      else retry_delay <= cfg_data;
    end
  end

  // captured input word
  logic [1:0]  r_cmd, r_tr, r_sel;
  logic [63:0] r_now;
  logic        r_cok, r_chok, r_txok;
  entry_t      r_new;
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      r_cmd <= command;
      r_tr <= transport;
      r_sel <= counter_select;
      r_now <= now;
      r_cok <= country_ok;
      r_chok <= channel_ok;
      r_txok <= transmit_ok;
      r_new <= '{deadline, sequence_number, payload_handle, payload_length};
    end
  end

  // scheduler state
  logic [CNT_W-1:0] qcount [2];
  logic        active_band, country_done;
  logic [7:0]  current_channel;
  logic [63:0] dwell_start, retry_at;
  logic [63:0] counters [8];

  // entry memory, address is band then slot
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;
  dbts_ram #(.WIDTH(ENTRY_W), .DEPTH(2 * QUEUE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  function automatic logic payload_ok(input logic [9:0] len);
    payload_ok = (len != 10'd0) && ({22'd0, len} <= MAX_PAYLOAD);
  endfunction

  // poll decision, evaluated in the decide cycle
  logic act, oth, target, sw, ok_len, dec_band;
  logic poll_pass, sw_go, chan_fail, go_scan, submit_take;
  logic [CNT_W-1:0] n_act, n_oth;
  logic [63:0] elapsed, retry_sum;
  logic        retry_carry;
  always_comb begin
    act = active_band;
    oth = ~active_band;
    n_act = qcount[act];
    n_oth = qcount[oth];
    elapsed = r_now - dwell_start;
    {retry_carry, retry_sum} = {1'b0, r_now} + {33'd0, retry_delay};
    target = act;
    sw = (current_channel == 8'd0);
    if (current_channel == 8'd0 && n_act == '0) target = oth;
    if (current_channel != 8'd0 && n_act == '0 && n_oth != '0) begin
      target = oth;
      sw = 1'b1;
    end else if (current_channel != 8'd0 && n_act != '0 && n_oth != '0 &&
                 elapsed >= {32'd0, dwell_time}) begin
      target = oth;
      sw = 1'b1;
    end
    ok_len = payload_ok(r_new.length);
    dec_band = sw ? target : act;
    poll_pass = (r_cmd == CMD_POLL) && (qcount[0] != '0 || qcount[1] != '0) &&
                (country_done || r_cok);
    sw_go = poll_pass && sw && (r_now >= retry_at);
    chan_fail = sw_go && !r_chok;
    go_scan = sw ? (sw_go && r_chok && qcount[target] != '0)
                 : (poll_pass && n_act != '0);
    submit_take = (r_cmd == CMD_SUBMIT) && !r_tr[1] && ok_len &&
                  (qcount[r_tr[0]] < CNT_W'(QUEUE_DEPTH));
  end

  // scan and shift bookkeeping
  logic             band;      // band being served
  logic [IDX_W-1:0] rd_idx;    // shift read slot
  logic [CNT_W-1:0] seen;      // slots already compared
  logic [IDX_W-1:0] best_idx;
  entry_t           best;
  logic [IDX_W-1:0] sh_idx;    // slot being written in the shift
  logic             shifting_first;

  logic better;
  always_comb begin
    better = (ram_rdata.deadline < best.deadline) ||
             (ram_rdata.deadline == best.deadline &&
              ram_rdata.sequence_number < best.sequence_number);
  end

  logic [CNT_W-1:0] nb;
  assign nb = qcount[band];

  logic issue_ok;
  assign issue_ok = r_txok;

  assign stat.go_scan = go_scan;
  assign stat.scan_last = (seen + 1'b1 >= nb);
  assign stat.need_shift = issue_ok;
  assign stat.shift_last = shifting_first ? (CNT_W'(sh_idx) + CNT_W'(1) >= nb)
                                          : (CNT_W'(sh_idx) + CNT_W'(2) >= nb);

  // read address: decide fetches slot zero, scan runs one slot ahead,
  // shift reads the slot above
  always_comb begin
    if (ctrl.decide) ram_raddr = {dec_band, IDX_W'(0)};
    else if (ctrl.scan_step) ram_raddr = {band, seen[IDX_W-1:0] + IDX_W'(1)};
    else ram_raddr = {band, rd_idx};
    ram_we = 1'b0;
    ram_waddr = {r_tr[0], qcount[r_tr[0]][IDX_W-1:0]};
    ram_wdata = r_new;
    if (ctrl.decide && submit_take) begin
      ram_we = 1'b1;
    end
    if (ctrl.shift_step && !shifting_first) begin
      ram_we = 1'b1;
      ram_waddr = {band, sh_idx};
      ram_wdata = ram_rdata;
    end
  end

  function automatic logic [63:0] sat_inc(input logic [63:0] v);
    sat_inc = (v == '1) ? v : v + 64'd1;
  endfunction

  logic [2:0] bump_k;
  logic       bump_en;
  logic       bump_fire;

  // counter bump requests
  always_comb begin
    bump_fire = (ctrl.decide && (submit_take || chan_fail)) || ctrl.issue ||
                (ctrl.shift_step && shifting_first && tx_late);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qcount[0] <= '0;
      qcount[1] <= '0;
      active_band <= 1'b0;
      country_done <= 1'b0;
      current_channel <= 8'd0;
      dwell_start <= '0;
      retry_at <= '0;
      for (int i = 0; i < 8; i++) counters[i] <= '0;
      bump_en <= 1'b0;
    end else begin
      bump_en <= bump_fire;
      if (bump_en) counters[bump_k] <= sat_inc(counters[bump_k]);

      if (ctrl.load) begin
        status <= ST_OK;
        country_request <= 1'b0;
        channel_request <= 8'd0;
        tx_valid <= 1'b0;
        tx_handle <= '0;
        tx_length <= '0;
        tx_late <= 1'b0;
        read_value <= '0;
      end

      if (ctrl.decide) begin
        case (r_cmd)
          CMD_SUBMIT: begin
            if (r_tr[1] || !ok_len) begin
              status <= ST_INVALID;
            end else if (qcount[r_tr[0]] >= CNT_W'(QUEUE_DEPTH)) begin
              status <= ST_FULL;
            end else begin
              qcount[r_tr[0]] <= qcount[r_tr[0]] + 1'b1;
              bump_k <= {r_tr[0], CNT_EXPECTED};
            end
          end
          CMD_READ: begin
            if (!r_tr[1]) read_value <= counters[{r_tr[0], r_sel}];
          end
          CMD_POLL: begin
            if (qcount[0] != '0 || qcount[1] != '0) begin
              if (!country_done && !r_cok) begin
                country_request <= 1'b1;
                status <= ST_COUNTRY;
              end else begin
                country_request <= !country_done;
                country_done <= 1'b1;
                if (sw) begin
                  if (r_now >= retry_at) begin
                    channel_request <= target ? CHAN_HIGH : CHAN_LOW;
                    if (!r_chok) begin
                      retry_at <= retry_carry ? '1 : retry_sum;
                      status <= ST_CHANNEL;
                      bump_k <= {target, CNT_ERRORS};
                    end else begin
                      active_band <= target;
                      current_channel <= target ? CHAN_HIGH : CHAN_LOW;
                      dwell_start <= r_now;
                      retry_at <= '0;
                      band <= target;
                    end
                  end
                end else begin
                  band <= act;
                end
              end
            end
          end
          default: status <= ST_INVALID;
        endcase
      end

      // scan: slot k arrives in scan step k
      if (ctrl.scan_start) begin
        seen <= '0;
      end
      if (ctrl.scan_step) begin
        if (seen == '0 || better) begin
          best <= ram_rdata;
          best_idx <= seen[IDX_W-1:0];
        end
        seen <= seen + 1'b1;
      end

      if (ctrl.issue) begin
        tx_valid <= 1'b1;
        tx_handle <= best.handle;
        tx_length <= best.length;
        if (!issue_ok) begin
          status <= ST_TRANSMIT;
          bump_k <= {band, CNT_ERRORS};
        end else begin
          bump_k <= {band, CNT_SUBMITTED};
          tx_late <= (r_now > best.deadline);
          sh_idx <= best_idx;
          rd_idx <= best_idx + 1'b1;
          shifting_first <= 1'b1;
        end
      end

      // late counter bumps in the cycle after the submitted counter
      if (ctrl.shift_step && shifting_first && tx_late) begin
        bump_k <= {band, CNT_LATE};
      end

      if (ctrl.shift_step) begin
        if (shifting_first) begin
          shifting_first <= 1'b0;
          rd_idx <= rd_idx + 1'b1;
        end else begin
          sh_idx <= sh_idx + 1'b1;
          rd_idx <= rd_idx + 1'b1;
        end
        if (stat.shift_last) qcount[band] <= nb - 1'b1;
      end
    end
  end

  assign low_band_depth = 4'(qcount[0]);
  assign high_band_depth = 4'(qcount[1]);

endmodule

### src/dual_band_deadline_tx_scheduler.sv
// ----------------------------------------------------------------------------
// dual_band_deadline_tx_scheduler
// Two band transmit queues with earliest deadline selection.
//
//   channel  direction  handshake           contents
//   in       input      in_valid/in_stall   command word
//   out      output     out_valid/out_stall result word
//   cfg      input      cfg_valid/cfg_ready register index and data
//
// submit and read go from acceptance through the decide state to the result;
// a poll that goes on to selection adds a scan over the band's entries, an
// issue state and, on success, a shift down of the entries above the issued
// one through the one read port of the entry RAM
// reset is synchronous; entry memory is not cleared, counts gate every read
// a held result stalls the block until the word is taken
// ----------------------------------------------------------------------------
module dual_band_deadline_tx_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [1:0]  transport,
  input  logic [63:0] deadline,
  input  logic [31:0] sequence_number,
  input  logic [15:0] payload_handle,
  input  logic [9:0]  payload_length,
  input  logic [63:0] now,
  input  logic        country_ok,
  input  logic        channel_ok,
  input  logic        transmit_ok,
  input  logic [1:0]  counter_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        country_request,
  output logic [7:0]  channel_request,
  output logic        tx_valid,
  output logic [15:0] tx_handle,
  output logic [9:0]  tx_length,
  output logic        tx_late,
  output logic [63:0] read_value,
  output logic [3:0]  low_band_depth,
  output logic [3:0]  high_band_depth,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dbts_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  busy;

  assign in_stall = busy;
  assign cfg_ready = 1'b1;

  dbts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_take(in_valid & ~busy), .out_free(~out_stall),
    .stat(stat), .ctrl(ctrl), .busy(busy), .result_valid(out_valid)
  );

  dbts_dp u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index[0]), .cfg_data(cfg_data),
    .command(command), .transport(transport), .deadline(deadline),
    .sequence_number(sequence_number), .payload_handle(payload_handle),
    .payload_length(payload_length), .now(now), .country_ok(country_ok),
    .channel_ok(channel_ok), .transmit_ok(transmit_ok),
    .counter_select(counter_select), .status(status),
    .country_request(country_request), .channel_request(channel_request),
    .tx_valid(tx_valid), .tx_handle(tx_handle), .tx_length(tx_length),
    .tx_late(tx_late), .read_value(read_value),
    .low_band_depth(low_band_depth), .high_band_depth(high_band_depth)
  );

endmodule

### verif/tb_dual_band_deadline_tx_scheduler.sv
// ----------------------------------------------------------------------------
// tb_dual_band_deadline_tx_scheduler
// Self-checking bench for the two band deadline transmit scheduler.
//
// A behavioral scheduler model predicts every result word from the accepted
// command words. A checker compares each accepted result word field by field
// against the oldest prediction. Directed words cover the corner cases first.
// Random phases then run under several register settings and several
// sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_dual_band_deadline_tx_scheduler;
  import dbts_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [1:0] TR_LOW = 2'd0;
  localparam logic [1:0] TR_HIGH = 2'd1;
  localparam logic [1:0] TR_BAD = 2'd2;
  localparam logic [1:0] TR_BAD_HI = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [1:0]  cmd;
    logic [1:0]  tr;
    logic [63:0] dl;
    logic [31:0] sq;
    logic [15:0] hnd;
    logic [9:0]  len;
    logic [63:0] t;
    logic        cok;
    logic        chok;
    logic        txok;
    logic [1:0]  sel;
  } word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        country;
    logic [7:0]  chan;
    logic        txv;
    logic [15:0] txh;
    logic [9:0]  txl;
    logic        late;
    logic [63:0] rd;
    logic [3:0]  d0;
    logic [3:0]  d1;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = '0;
  logic [1:0]  transport = '0;
  logic [63:0] deadline = '0;
  logic [31:0] sequence_number = '0;
  logic [15:0] payload_handle = '0;
  logic [9:0]  payload_length = '0;
  logic [63:0] now = '0;
  logic        country_ok = 1'b0;
  logic        channel_ok = 1'b0;
  logic        transmit_ok = 1'b0;
  logic [1:0]  counter_select = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        country_request;
  logic [7:0]  channel_request;
  logic        tx_valid;
  logic [15:0] tx_handle;
  logic [9:0]  tx_length;
  logic        tx_late;
  logic [63:0] read_value;
  logic [3:0]  low_band_depth;
  logic [3:0]  high_band_depth;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  dual_band_deadline_tx_scheduler dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // scheduler model state
  logic [63:0] m_deadline [2][QUEUE_DEPTH];
  logic [31:0] m_sequence [2][QUEUE_DEPTH];
  logic [15:0] m_handle [2][QUEUE_DEPTH];
  logic [9:0]  m_length [2][QUEUE_DEPTH];
  int          m_count [2];
  logic        m_active;
  logic [7:0]  m_channel;
  logic [63:0] m_dwell_start;
  logic [63:0] m_retry_at;
  logic        m_country_done;
  logic [63:0] m_counters [8];
  logic [31:0] m_dwell_time;
  logic [31:0] m_retry_delay;
  result_t     pr;

  result_t pending_results[$];
  int      fails = 0;
  int      send_idle = 0;
  int      recv_stall = 0;
  int      quiet_cycles = 0;
  logic [63:0] clock_ms = 64'd1000;

  function automatic void model_reset();
    m_count[0] = 0;
    m_count[1] = 0;
    m_active = 1'b0;
    m_channel = '0;
    m_dwell_start = '0;
    m_retry_at = '0;
    m_country_done = 1'b0;
    for (int i = 0; i < 8; i++) m_counters[i] = '0;
    m_dwell_time = 32'd100;
    m_retry_delay = 32'd50;
  endfunction

  function automatic void bump(logic b, logic [1:0] which);
    int k;
    k = {b, which};
    if (m_counters[k] != '1) m_counters[k] = m_counters[k] + 1;
  endfunction

  function automatic logic [7:0] chan_of_band(logic b);
    return b ? CHAN_HIGH : CHAN_LOW;
  endfunction

  function automatic void submit_model(word_t w);
    int n;
    if (w.tr > TR_HIGH || w.len == 0 || w.len > MAX_PAYLOAD) begin
      pr.status = ST_INVALID;
      return;
    end
    n = m_count[w.tr[0]];
    if (n >= QUEUE_DEPTH) begin
      pr.status = ST_FULL;
      return;
    end
    m_deadline[w.tr[0]][n] = w.dl;
    m_sequence[w.tr[0]][n] = w.sq;
    m_handle[w.tr[0]][n] = w.hnd;
    m_length[w.tr[0]][n] = w.len;
    m_count[w.tr[0]] = n + 1;
    bump(w.tr[0], CNT_EXPECTED);
    pr.status = ST_OK;
  endfunction

  function automatic void poll_model(word_t w);
    logic act, oth, target, sw;
    int best;
    act = m_active;
    oth = ~act;
    target = act;
    if (m_count[0] == 0 && m_count[1] == 0) return;
    if (!m_country_done) begin
      pr.country = 1'b1;
      if (!w.cok) begin
        pr.status = ST_COUNTRY;
        return;
      end
      m_country_done = 1'b1;
    end
    // channel switch decision
    sw = (m_channel == 0);
    if (m_channel == 0 && m_count[act] == 0) target = oth;
    if (m_channel != 0 && m_count[act] == 0 && m_count[oth] != 0) begin
      target = oth;
      sw = 1'b1;
    end else if (m_channel != 0 && m_count[act] != 0 && m_count[oth] != 0 &&
                 (w.t - m_dwell_start) >= {32'd0, m_dwell_time}) begin
      target = oth;
      sw = 1'b1;
    end
    if (sw) begin
      if (w.t < m_retry_at) return;
      pr.chan = chan_of_band(target);
      if (!w.chok) begin
        m_retry_at = (w.t > ~{32'd0, m_retry_delay}) ? '1 : w.t + m_retry_delay;
        bump(target, CNT_ERRORS);
        pr.status = ST_CHANNEL;
        return;
      end
      m_active = target;
      m_channel = chan_of_band(target);
      m_dwell_start = w.t;
      m_retry_at = '0;
      act = target;
    end
    if (m_count[act] == 0) return;
    // earliest deadline, lower sequence on ties
    best = 0;
    for (int i = 1; i < m_count[act]; i++)
      if (m_deadline[act][i] < m_deadline[act][best] ||
          (m_deadline[act][i] == m_deadline[act][best] &&
           m_sequence[act][i] < m_sequence[act][best])) best = i;
    pr.txv = 1'b1;
    pr.txh = m_handle[act][best];
    pr.txl = m_length[act][best];
    if (!w.txok) begin
      bump(act, CNT_ERRORS);
      pr.status = ST_TRANSMIT;
      return;
    end
    bump(act, CNT_SUBMITTED);
    if (w.t > m_deadline[act][best]) begin
      pr.late = 1'b1;
      bump(act, CNT_LATE);
    end
    for (int i = best + 1; i < m_count[act]; i++) begin
      m_deadline[act][i-1] = m_deadline[act][i];
      m_sequence[act][i-1] = m_sequence[act][i];
      m_handle[act][i-1] = m_handle[act][i];
      m_length[act][i-1] = m_length[act][i];
    end
    m_count[act] = m_count[act] - 1;
  endfunction

  function automatic result_t predict_result(word_t w);
    pr = '0;
    case (w.cmd)
      CMD_SUBMIT: submit_model(w);
      CMD_POLL: poll_model(w);
      CMD_READ: begin
        if (w.tr <= TR_HIGH) pr.rd = m_counters[{w.tr[0], w.sel}];
      end
      default: pr.status = ST_INVALID;
    endcase
    pr.d0 = 4'(m_count[0]);
    pr.d1 = 4'(m_count[1]);
    return pr;
  endfunction

  // send one command word, with random idle cycles ahead of it
  task automatic send_word(word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= w.cmd;
    transport <= w.tr;
    deadline <= w.dl;
    sequence_number <= w.sq;
    payload_handle <= w.hnd;
    payload_length <= w.len;
    now <= w.t;
    country_ok <= w.cok;
    channel_ok <= w.chok;
    transmit_ok <= w.txok;
    counter_select <= w.sel;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_results.push_back(predict_result(w));
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    end_burst();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    if (idx == CFG_DWELL) m_dwell_time = data;
    else m_retry_delay = data;
  endtask

  function automatic word_t blank_word(logic [1:0] cmd, logic [1:0] tr);
    word_t w;
    w = '{cmd: cmd, tr: tr, dl: '0, sq: '0, hnd: '0, len: 10'd1, t: '0,
          cok: 1'b1, chok: 1'b1, txok: 1'b1, sel: CNT_EXPECTED};
    return w;
  endfunction

  task automatic submit(logic [1:0] tr, logic [63:0] dl, logic [31:0] sq,
                        logic [15:0] hnd, logic [9:0] len);
    word_t w;
    w = blank_word(CMD_SUBMIT, tr);
    w.dl = dl;
    w.sq = sq;
    w.hnd = hnd;
    w.len = len;
    send_word(w);
  endtask

  task automatic poll(logic [63:0] t, logic cok, logic chok, logic txok);
    word_t w;
    w = blank_word(CMD_POLL, TR_LOW);
    w.t = t;
    w.cok = cok;
    w.chok = chok;
    w.txok = txok;
    send_word(w);
  endtask

  // corner cases of submit, poll and read
  task automatic test_directed();
    word_t w;
    poll(64'd10, 1'b1, 1'b1, 1'b1);
    w = blank_word(CMD_UNKNOWN, TR_BAD_HI);
    w.dl = '1;
    w.sq = '1;
    w.hnd = '1;
    w.len = '1;
    w.t = '1;
    w.sel = CNT_ERRORS;
    send_word(w);
    submit(TR_BAD, 64'd5, 32'd0, 16'h1234, 10'd4);
    submit(TR_BAD_HI, 64'd5, 32'd0, 16'h1234, 10'd4);
    submit(TR_LOW, 64'd5, 32'd0, 16'h1234, 10'd0);
    submit(TR_LOW, '1, '1, 16'hffff, 10'd1023);
    submit(TR_HIGH, 64'd0, 32'd0, 16'h0000, 10'd1);
    poll(64'd20, 1'b0, 1'b1, 1'b1);
    poll(64'd30, 1'b1, 1'b0, 1'b1);
    poll(64'd40, 1'b1, 1'b1, 1'b1);
    poll(64'd80, 1'b1, 1'b1, 1'b0);
    poll(64'd90, 1'b1, 1'b1, 1'b1);
    // equal deadlines; the high queue already holds one entry, so the last two submits are refused
    for (int i = 0; i < QUEUE_DEPTH; i++)
      submit(TR_HIGH, 64'd500, 32'(32'd20 - i), 16'(16'h100 + i), 10'(10'd10 + i));
    submit(TR_HIGH, 64'd1, 32'd0, 16'hdead, 10'd3);
    poll(64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 1'b1);
    w = blank_word(CMD_READ, TR_BAD);
    send_word(w);
    for (int i = 0; i < 4; i++) begin
      w = blank_word(CMD_READ, i[0] ? TR_HIGH : TR_LOW);
      w.sel = 2'(i);
      send_word(w);
    end
    wait_drain();
  endtask

  function automatic word_t random_word();
    word_t w;
    int pick;
    pick = $urandom_range(99);
    w = blank_word(CMD_SUBMIT, TR_LOW);
    w.tr = ($urandom_range(19) == 0) ? 2'($urandom) : 2'($urandom_range(1));
    w.sel = 2'($urandom);
    if (pick < 45) begin
      w.cmd = CMD_SUBMIT;
      w.dl = clock_ms + $urandom_range(300) - 40;
      if ($urandom_range(29) == 0) w.dl = {$urandom, $urandom};
      w.sq = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
      w.hnd = 16'($urandom);
      w.len = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(1, 1023));
    end else if (pick < 85) begin
      w.cmd = CMD_POLL;
      clock_ms = clock_ms + $urandom_range(40);
      w.t = clock_ms;
      if ($urandom_range(49) == 0) w.t = {$urandom, $urandom};
      if ($urandom_range(99) == 0) w.t = '1;
      w.cok = $urandom_range(9) != 0;
      w.chok = $urandom_range(4) != 0;
      w.txok = $urandom_range(4) != 0;
    end else if (pick < 96) begin
      w.cmd = CMD_READ;
    end else begin
      w = '{cmd: 2'($urandom), tr: 2'($urandom), dl: {$urandom, $urandom},
            sq: $urandom, hnd: 16'($urandom), len: 10'($urandom),
            t: {$urandom, $urandom}, cok: 1'($urandom), chok: 1'($urandom),
            txok: 1'($urandom), sel: 2'($urandom)};
    end
    return w;
  endfunction

  // random traffic under one register setting and one idle pattern
  task automatic test_random_phase(logic [31:0] dwell, logic [31:0] retry,
                                   int idle, int stall, int count);
    write_reg(CFG_DWELL, dwell);
    write_reg(CFG_RETRY, retry);
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < count; i++) send_word(random_word());
    wait_drain();
  endtask

  // result checker and receiver stall
  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result word: status %0h", $time, status);
        fails++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", 64'(e.status), 64'(status));
        check_field("country_request", 64'(e.country), 64'(country_request));
        check_field("channel_request", 64'(e.chan), 64'(channel_request));
        check_field("tx_valid", 64'(e.txv), 64'(tx_valid));
        check_field("tx_handle", 64'(e.txh), 64'(tx_handle));
        check_field("tx_length", 64'(e.txl), 64'(tx_length));
        check_field("tx_late", 64'(e.late), 64'(tx_late));
        check_field("read_value", e.rd, read_value);
        check_field("low_band_depth", 64'(e.d0), 64'(low_band_depth));
        check_field("high_band_depth", 64'(e.d1), 64'(high_band_depth));
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(32'd100, 32'd50, 0, 0, 90);
    test_random_phase(32'd0, 32'd0, 72, 0, 90);
    test_random_phase(32'hffff_ffff, 32'hffff_ffff, 0, 72, 90);
    test_random_phase(32'd10, 32'd5, 15, 15, 90);
    test_random_phase($urandom_range(200), $urandom_range(100), 0, 0, 90);
    test_random_phase(32'd30, 32'hffff_ffff, 15, 15, 60);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
